// File: src/dedup_resume_ring_defines.svh
// ----------------------------------------------------------------------------
// Deduplicating resume ring assertion macros
// Shared property wrappers for the checker; each expects clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef DEDUP_RESUME_RING_DEFINES_SVH
`define DEDUP_RESUME_RING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/drr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deduplicating resume ring package
// Shared types, codes and field layout constants.
// ----------------------------------------------------------------------------
package drr_pkg;

    localparam int ID_W         = 62;
    localparam int SLOT_W       = 8;
    localparam int STREAM_SLOTS = 256;
    localparam int LIMIT_W      = 6;
    localparam int MAX_RESULTS  = 32;
    localparam int STATUS_W     = 3;
    localparam int RC_W         = 6;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TUSER_W = 4;

    localparam int SLOT_LSB  = 0;
    localparam int ID_LSB    = SLOT_LSB + SLOT_W;
    localparam int LIMIT_LSB = ID_LSB + ID_W;

    localparam int POP_LSB = 0;
    localparam int RC_LSB  = POP_LSB + ID_W;
    localparam int WAKE_BIT = STATUS_W;

    typedef enum logic [1:0] {
        OP_RESUME = 2'd0,
        OP_DRAIN  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPTED        = 3'd0,
        STAT_COALESCED       = 3'd1,
        STAT_REFUSED_STOPPED = 3'd2,
        STAT_REFUSED_FULL    = 3'd3,
        STAT_DRAINED         = 3'd4,
        STAT_DRAIN_EMPTY     = 3'd5
    } status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [LIMIT_W-1:0] limit;
        logic               limit_zero;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   popped_id;
        logic              last;
        logic              wake;
        logic [RC_W-1:0]   ring_count;
    } result_t;

endpackage

// File: src/drr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deduplicating resume ring front end
// Accepts input transfers, decodes the operation and caps the drain limit.
// ----------------------------------------------------------------------------
module drr_front
    import drr_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [IN_TUSER_W-1:0] s_tuser,
    input  logic                  queue_full,
    output logic                  push,
    output cmd_t                  cmd
);

    logic [LIMIT_W-1:0] raw_limit;

    assign raw_limit = s_tdata[LIMIT_LSB +: LIMIT_W];
    assign s_tready  = !queue_full;
    assign push      = s_tvalid && !queue_full;

    always_comb
    begin
        cmd.op         = op_t'(s_tuser[1:0]);
        cmd.slot       = s_tdata[SLOT_LSB +: SLOT_W];
        cmd.id         = s_tdata[ID_LSB +: ID_W];
        cmd.limit      = (raw_limit > LIMIT_W'(MAX_RESULTS)) ? LIMIT_W'(MAX_RESULTS) : raw_limit;
        cmd.limit_zero = (raw_limit == '0);
    end

endmodule

// File: src/drr_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deduplicating resume ring command queue
// Two-entry queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module drr_cmd_queue
    import drr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full      = (fill_reg == 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/drr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deduplicating resume ring back end
// Holds the ring, the enqueued flags and the stop mode, and executes commands.
// ----------------------------------------------------------------------------
module drr_back
    import drr_pkg::*;
#(
    parameter int RING_DEPTH = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  logic    wake_enable,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] idx);
        return (idx == ADDR_W'(RING_DEPTH - 1)) ? '0 : idx + ADDR_W'(1);
    endfunction

    logic [ID_W-1:0]         ring_mem [RING_DEPTH];
    logic [ID_W-1:0]         rd_data_reg;
    back_state_t             state_reg;
    back_state_t             state_next;
    logic [ADDR_W-1:0]       head_reg;
    logic [ADDR_W-1:0]       head_next;
    logic [ADDR_W-1:0]       tail_reg;
    logic [ADDR_W-1:0]       tail_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [LIMIT_W-1:0]      rem_reg;
    logic [LIMIT_W-1:0]      rem_next;
    logic                    stopped_reg;
    logic                    stopped_next;
    logic [STREAM_SLOTS-1:0] flags_reg;
    logic [STREAM_SLOTS-1:0] flags_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    result_t                 out_reg;
    result_t                 out_load;
    logic                    load;
    logic                    out_free;
    logic                    wr_en;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    drain_fin;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        stopped_next = stopped_reg;
        flags_next   = flags_reg;
        cmd_pop      = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = head_reg;
        load         = 1'b0;
        drain_fin    = 1'b0;
        out_load     = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_RESUME:
                        begin
                            load          = 1'b1;
                            out_load.last = 1'b1;
                            if (flags_reg[cmd.slot])
                            begin
                                out_load.status = STAT_COALESCED;
                            end
                            else if (stopped_reg)
                            begin
                                out_load.status = STAT_REFUSED_STOPPED;
                            end
                            else if (count_reg == CNT_W'(RING_DEPTH))
                            begin
                                out_load.status = STAT_REFUSED_FULL;
                            end
                            else
                            begin
                                out_load.status       = STAT_ACCEPTED;
                                out_load.wake         = wake_enable && (count_reg == '0);
                                wr_en                 = 1'b1;
                                tail_next             = next_idx(tail_reg);
                                count_next            = count_reg + CNT_W'(1);
                                flags_next[cmd.slot]  = 1'b1;
                            end
                            out_load.ring_count = RC_W'(count_next);
                        end
                        OP_DRAIN:
                        begin
                            if ((count_reg == '0) || cmd.limit_zero)
                            begin
                                load                = 1'b1;
                                out_load.status     = STAT_DRAIN_EMPTY;
                                out_load.last       = 1'b1;
                                out_load.ring_count = RC_W'(count_reg);
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rem_next   = cmd.limit;
                                state_next = BK_EMIT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            flags_next[cmd.slot] = 1'b0;
                        end
                        OP_STOP:
                        begin
                            stopped_next = 1'b1;
                            head_next    = '0;
                            tail_next    = '0;
                            count_next   = '0;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    drain_fin           = (rem_reg == LIMIT_W'(1)) || (count_reg == CNT_W'(1));
                    load                = 1'b1;
                    head_next           = next_idx(head_reg);
                    count_next          = count_reg - CNT_W'(1);
                    rem_next            = rem_reg - LIMIT_W'(1);
                    out_load.status     = STAT_DRAINED;
                    out_load.popped_id  = rd_data_reg;
                    out_load.last       = drain_fin;
                    out_load.ring_count = RC_W'(count_next);
                    if (drain_fin)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = head_next;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            stopped_reg   <= 1'b0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            stopped_reg   <= stopped_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[tail_reg] <= cmd.id;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

endmodule

// File: src/dedup_resume_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deduplicating resume ring
// Ring of stream IDs in which each stream slot is queued at most once.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream (op in s_tuser) and results leave on the
// m_ stream, one transfer per result; m_tlast marks the final result of a
// command. Clear and stop commands produce no result. The cfg channel writes
// wake_enable and is always ready.
// A command enters a two-entry queue and the execution unit takes it from
// there once the result register is free, then registers its result.
// Requests, clears and stops sustain one command per cycle while m_tready
// is high and no drain is in progress. A drain first reads the ring memory
// into the registered read port; after that the read port delivers one
// popped ID per cycle while m_tready is high.
// Reset clears the enqueued flags, the ring pointers, the stop mode and
// wake_enable; the block accepts commands right after reset.
// When m_tready is low the result register holds its transfer and the
// execution unit waits; input transfers continue until the queue fills.
// ----------------------------------------------------------------------------
module dedup_resume_ring
    import drr_pkg::*;
#(
    parameter int RING_DEPTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // stream_slot, stream_id, drain_max, zero pad
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // popped_id, ring_count, zero pad
    output logic                   m_tlast,
    output logic [OUT_TUSER_W-1:0] m_tuser,   // status, wake
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    logic    wake_enable_reg;
    logic    wake_enable_next;
    logic    q_full;
    logic    q_push;
    cmd_t    q_in;
    logic    q_pop;
    logic    q_valid;
    cmd_t    q_out;
    result_t res;

    assign cfg_ready        = 1'b1;
    assign wake_enable_next = (cfg_valid && cfg_ready) ? cfg_data : wake_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_enable_reg <= 1'b0;
        end
        else
        begin
            wake_enable_reg <= wake_enable_next;
        end
    end

    drr_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (q_full),
        .push       (q_push),
        .cmd        (q_in)
    );

    drr_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_out)
    );

    drr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (q_out),
        .cmd_pop     (q_pop),
        .wake_enable (wake_enable_reg),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {(OUT_TDATA_W - ID_W - RC_W)'(0), res.ring_count, res.popped_id};
    assign m_tuser = {res.wake, res.status};
    assign m_tlast = res.last;

endmodule

// File: src/drr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deduplicating resume ring port checker
// Checks result stream properties seen at the top level ports.
// ----------------------------------------------------------------------------
`include "dedup_resume_ring_defines.svh"

module drr_checker
    import drr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tlast,
    input  logic [OUT_TUSER_W-1:0] m_tuser
);

    logic [STATUS_W-1:0]                status;
    logic [RC_W-1:0]                    ring_count;
    logic [ID_W-1:0]                    popped_id;
    logic [OUT_TDATA_W+OUT_TUSER_W:0]   beat;
    logic                               drained;
    logic                               stalled;
    logic                               wake_out;
    logic                               first_push;

    assign status     = m_tuser[STATUS_W-1:0];
    assign ring_count = m_tdata[RC_LSB +: RC_W];
    assign popped_id  = m_tdata[POP_LSB +: ID_W];
    assign beat       = {m_tlast, m_tuser, m_tdata};
    assign drained    = (status == STAT_DRAINED);
    assign stalled    = m_tvalid && !m_tready;
    assign wake_out   = m_tvalid && m_tuser[WAKE_BIT];
    assign first_push = (status == STAT_ACCEPTED) && (ring_count == RC_W'(1));

    `DRR_ASSERT_NEXT(a_stall_hold, stalled, m_tvalid && $stable(beat), "stalled result changed")
    `DRR_ASSERT_SAME(a_wake_first, wake_out, first_push, "wake without push onto empty ring")
    `DRR_ASSERT_SAME(a_single_last, m_tvalid && !drained, m_tlast, "single result without last")
    `DRR_ASSERT_SAME(a_id_zero, m_tvalid && !drained, popped_id == '0, "nonzero id outside drain")

endmodule

bind dedup_resume_ring drr_checker u_drr_checker (.*);
